// ----- src/ple_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Command and status codes and field widths of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CmdBits    = 3;
  localparam int PosBits    = 7;
  localparam int ValBits    = 32;
  localparam int StatusBits = 2;
  localparam int CountBits  = 7;

  typedef enum logic [CmdBits-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AFTER = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_LAST  = 3'd4,
    CMD_DEL_POS   = 3'd5
  } cmd_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

// ----- src/ple_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_if
// Valid/ready channels of the positional list engine: command in, report out.
// ----------------------------------------------------------------------------
interface ple_in_if;
  logic                         valid;
  logic                         ready;
  logic [ple_pkg::CmdBits-1:0]  cmd;
  logic [ple_pkg::PosBits-1:0]  position;
  logic signed [ple_pkg::ValBits-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface ple_out_if;
  logic                           valid;
  logic                           ready;
  logic [ple_pkg::StatusBits-1:0] status;
  logic [ple_pkg::CountBits-1:0]  element_count;
  logic                           middle_valid;
  logic signed [ple_pkg::ValBits-1:0] middle_value;

  modport source (output valid, output status, output element_count, output middle_valid,
                  output middle_value, input ready);
  modport sink   (input valid, input status, input element_count, input middle_valid,
                  input middle_value, output ready);
endinterface

// ----- src/positional_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Circular singly linked list in a slot store with a free-slot stack.
// ----------------------------------------------------------------------------
// One command beat at a time. A command walks k link hops to its target, and
// then max(n/2,1) hops from the tail to the middle element, where k is 1 for
// front/back inserts, 2 for delete first, position+1 for positional ones
// (position 0 counting as 1) and n+2 for delete last, and n is the element
// count after the command; rejected commands and an insert into an empty list
// skip the first walk, and an empty result skips the second.
// Both walks advance one hop per cycle through the single read port of the
// link memory. The free-slot stack needs no clearing pass after reset: a low
// water mark tells never-written stack entries, which read as their own index.
// A finished report waits in an output register while the next beat is taken.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int LIST_DEPTH = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ple_in_if.sink      in_i,
  ple_out_if.source   out_o
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int HW = $clog2(LIST_DEPTH + 2);
  localparam int PW = (HW > ple_pkg::PosBits) ? HW : ple_pkg::PosBits;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FIRST  = 8'b0000_0010,
    S_WALK   = 8'b0000_0100,
    S_APPLY1 = 8'b0000_1000,
    S_APPLY2 = 8'b0001_0000,
    S_MSET   = 8'b0010_0000,
    S_MWALK  = 8'b0100_0000,
    S_VRD    = 8'b1000_0000
  } state_e;

  logic [VALUE_BITS-1:0] val_mem  [LIST_DEPTH];
  logic [AW-1:0]         link_mem [LIST_DEPTH];
  logic [AW-1:0]         free_mem [LIST_DEPTH];

  state_e                 state_q, state_d;
  ple_pkg::cmd_e          cmd_q, cmd_d;
  ple_pkg::status_e       status_q, status_d;
  logic [ple_pkg::ValBits-1:0] val_q, val_d;
  logic                   ins_q, ins_d;
  logic [HW-1:0]          hops_q, hops_d;
  logic [AW-1:0]          cur_q, cur_d;
  logic                   rd_src_q, rd_src_d;
  logic [AW-1:0]          p1_q, p1_d, p2_q, p2_d;
  logic [AW-1:0]          b_q, b_d, v_q, v_d, n_q, n_d;
  logic [AW-1:0]          slot_q, slot_d;
  logic [AW-1:0]          tail_q, tail_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          mark_q, mark_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic                   fresh_q, fresh_d;
  logic                   mvalid_q, mvalid_d;
  logic [AW-1:0]          free_rd_q, link_rd_q;
  logic [VALUE_BITS-1:0]  value_rd_q;

  logic                   out_valid_q, out_valid_d;
  ple_pkg::status_e       out_status_q, out_status_d;
  logic [ple_pkg::CountBits-1:0] out_count_q, out_count_d;
  logic                   out_mvalid_q, out_mvalid_d;
  logic [ple_pkg::ValBits-1:0] out_mid_q, out_mid_d;

  logic                   link_re, link_we, val_we, val_re, free_re, free_we;
  logic [AW-1:0]          link_wa, link_wd, val_wa, free_wa;
  logic [AW-1:0]          c, s_new, idx_new;
  logic [CW-1:0]          idx_cw;
  logic [PW-1:0]          pos_w, p_w, cnt_w, k_w;
  logic                   hop_go, accept, out_free;
  logic [63:0]            wide_val;
  logic signed [63:0]     ext_val;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free  = !out_valid_q || out_o.ready;

  assign c       = rd_src_q ? link_rd_q : cur_q;
  assign s_new   = fresh_q ? idx_q : free_rd_q;
  assign idx_cw  = CW'(LIST_DEPTH - 1) - count_q;
  assign idx_new = AW'(idx_cw);
  assign pos_w   = PW'(in_i.position);
  assign p_w     = (pos_w == '0) ? PW'(1) : pos_w;
  assign cnt_w   = PW'(count_q);
  assign hop_go  = ((state_q == S_WALK) || (state_q == S_MWALK)) && (hops_q != '0);
  assign wide_val = {32'd0, val_q};
  assign ext_val  = 64'(signed'(value_rd_q));

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    status_d = status_q;
    val_d    = val_q;
    ins_d    = ins_q;
    hops_d   = hops_q;
    cur_d    = cur_q;
    rd_src_d = rd_src_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    b_d      = b_q;
    v_d      = v_q;
    n_d      = n_q;
    slot_d   = slot_q;
    tail_d   = tail_q;
    count_d  = count_q;
    mark_d   = mark_q;
    idx_d    = idx_q;
    fresh_d  = fresh_q;
    mvalid_d = mvalid_q;
    k_w      = '0;
    link_re  = 1'b0;
    link_we  = 1'b0;
    link_wa  = b_q;
    link_wd  = n_q;
    val_we   = 1'b0;
    val_wa   = s_new;
    val_re   = 1'b0;
    free_re  = 1'b0;
    free_we  = 1'b0;
    free_wa  = AW'(CW'(LIST_DEPTH) - count_q);
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_mvalid_d = out_mvalid_q;
    out_mid_d    = out_mid_q;

    if (hop_go) begin
      link_re  = 1'b1;
      p2_d     = p1_q;
      p1_d     = c;
      cur_d    = c;
      rd_src_d = 1'b1;
      hops_d   = hops_q - HW'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d    = ple_pkg::cmd_e'(in_i.cmd);
          val_d    = in_i.value;
          status_d = ple_pkg::ST_OK;
          cur_d    = tail_q;
          rd_src_d = 1'b0;
          state_d  = S_MSET;
          unique case (in_i.cmd)
            ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_BACK, ple_pkg::CMD_INS_AFTER: begin
              if (count_q >= CW'(LIST_DEPTH)) begin
                status_d = ple_pkg::ST_FULL;
              end else if ((in_i.cmd == ple_pkg::CMD_INS_AFTER) && (count_q != '0) &&
                           (p_w > cnt_w)) begin
                status_d = ple_pkg::ST_RANGE;
              end else begin
                free_re = 1'b1;
                idx_d   = idx_new;
                fresh_d = idx_cw < mark_q;
                if (idx_cw < mark_q) mark_d = idx_cw;
                ins_d   = 1'b1;
                if (count_q == '0) begin
                  state_d = S_FIRST;
                end else begin
                  k_w     = (in_i.cmd == ple_pkg::CMD_INS_AFTER) ? p_w : '0;
                  hops_d  = HW'(k_w + PW'(1));
                  state_d = S_WALK;
                end
              end
            end
            ple_pkg::CMD_DEL_FIRST, ple_pkg::CMD_DEL_LAST, ple_pkg::CMD_DEL_POS: begin
              if (count_q == '0) begin
                status_d = ple_pkg::ST_EMPTY;
              end else if ((in_i.cmd == ple_pkg::CMD_DEL_POS) &&
                           ((pos_w == '0) || (pos_w > cnt_w))) begin
                status_d = ple_pkg::ST_RANGE;
              end else begin
                ins_d = 1'b0;
                unique case (in_i.cmd)
                  ple_pkg::CMD_DEL_FIRST: k_w = PW'(1);
                  ple_pkg::CMD_DEL_LAST:  k_w = cnt_w;
                  default:                k_w = pos_w;
                endcase
                hops_d  = HW'(k_w + PW'(1));
                state_d = S_WALK;
              end
            end
            default: begin
              status_d = ple_pkg::ST_OK;
            end
          endcase
        end
      end
      S_FIRST: begin
        val_we   = 1'b1;
        link_we  = 1'b1;
        link_wa  = s_new;
        link_wd  = s_new;
        tail_d   = s_new;
        count_d  = CW'(1);
        state_d  = S_MSET;
      end
      S_WALK: begin
        if (hops_q == '0) begin
          b_d      = ins_q ? p1_q : p2_q;
          v_d      = p1_q;
          n_d      = c;
          rd_src_d = 1'b0;
          state_d  = S_APPLY1;
        end
      end
      S_APPLY1: begin
        if (ins_q) begin
          val_we  = 1'b1;
          link_we = 1'b1;
          link_wa = s_new;
          link_wd = n_q;
          slot_d  = s_new;
          state_d = S_APPLY2;
        end else begin
          if (count_q > CW'(1)) begin
            link_we = 1'b1;
            if (v_q == tail_q) tail_d = b_q;
          end
          free_we = 1'b1;
          count_d = count_q - CW'(1);
          state_d = S_MSET;
        end
      end
      S_APPLY2: begin
        link_we = 1'b1;
        link_wd = slot_q;
        if ((cmd_q == ple_pkg::CMD_INS_BACK) ||
            ((cmd_q == ple_pkg::CMD_INS_AFTER) && (b_q == tail_q))) begin
          tail_d = slot_q;
        end
        count_d = count_q + CW'(1);
        state_d = S_MSET;
      end
      S_MSET: begin
        mvalid_d = (count_q != '0);
        cur_d    = tail_q;
        rd_src_d = 1'b0;
        hops_d   = (count_q > CW'(1)) ? HW'(count_q >> 1) : HW'(1);
        state_d  = (count_q != '0) ? S_MWALK : S_VRD;
      end
      S_MWALK: begin
        if (hops_q == '0) begin
          val_re   = 1'b1;
          rd_src_d = 1'b0;
          state_d  = S_VRD;
        end
      end
      S_VRD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_count_d  = ple_pkg::CountBits'(count_q);
          out_mvalid_d = mvalid_q;
          out_mid_d    = mvalid_q ? ext_val[31:0] : '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_rd_q <= link_mem[c];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= wide_val[VALUE_BITS-1:0];
    if (val_re) value_rd_q <= val_mem[c];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_wa] <= v_q;
    if (free_re) free_rd_q <= free_mem[idx_new];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tail_q      <= '0;
      count_q     <= '0;
      mark_q      <= CW'(LIST_DEPTH);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    status_q     <= status_d;
    val_q        <= val_d;
    ins_q        <= ins_d;
    hops_q       <= hops_d;
    cur_q        <= cur_d;
    rd_src_q     <= rd_src_d;
    p1_q         <= p1_d;
    p2_q         <= p2_d;
    b_q          <= b_d;
    v_q          <= v_d;
    n_q          <= n_d;
    slot_q       <= slot_d;
    idx_q        <= idx_d;
    fresh_q      <= fresh_d;
    mvalid_q     <= mvalid_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_mvalid_q <= out_mvalid_d;
    out_mid_q    <= out_mid_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.element_count = out_count_q;
  assign out_o.middle_valid  = out_mvalid_q;
  assign out_o.middle_value  = out_mid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LIST_DEPTH))
    else $error("element count exceeds depth");

  a_mark_below_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CW+1)'(mark_q) + (CW+1)'(count_q)) <= (CW+1)'(LIST_DEPTH))
    else $error("free stack mark above stack top");

  a_out_from_vrd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_VRD))
    else $error("report beat without a middle read");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("ready again right after a command beat");

  a_empty_mid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_mvalid_q) |-> (out_mid_q == '0))
    else $error("middle value nonzero on empty list");

endmodule

// ----- bench/tb_positional_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Checks the positional list engine against a list kept in the bench.
// Directed commands cover empty, full, range and unused-code cases; random
// phases then fill, churn and drain the list with random idles on both sides.
// Every report is compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;

  localparam int Depth = 64;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [ple_pkg::StatusBits-1:0] status;
    logic [ple_pkg::CountBits-1:0]  element_count;
    logic                           middle_valid;
    logic [ple_pkg::ValBits-1:0]    middle_value;
  } report_t;

  class list_scoreboard;
    logic [ple_pkg::ValBits-1:0] elems[$];
    report_t            pending[$];
    int                 errors;
    int                 checked;

    function void report_mismatch(string what, logic [ple_pkg::ValBits-1:0] want,
                                  logic [ple_pkg::ValBits-1:0] got);
      errors++;
      if (errors <= 50)
        $display("MISMATCH %s at report %0d: want %h got %h", what, checked, want, got);
    endfunction

    function void note_command(logic [ple_pkg::CmdBits-1:0] cmd,
                               logic [ple_pkg::PosBits-1:0] pos,
                               logic [ple_pkg::ValBits-1:0] val);
      report_t r;
      int      p;
      int      n;
      r = '0;
      r.status = ple_pkg::ST_OK;
      n = elems.size();
      p = (pos == 0) ? 1 : int'(pos);
      if (cmd == ple_pkg::CMD_INS_FRONT || cmd == ple_pkg::CMD_INS_BACK ||
          cmd == ple_pkg::CMD_INS_AFTER) begin
        if (n >= Depth) begin
          r.status = ple_pkg::ST_FULL;
        end else if (n == 0) begin
          elems.push_back(val);
        end else if (cmd == ple_pkg::CMD_INS_FRONT) begin
          elems.push_front(val);
        end else if (cmd == ple_pkg::CMD_INS_BACK) begin
          elems.push_back(val);
        end else if (p > n) begin
          r.status = ple_pkg::ST_RANGE;
        end else begin
          elems.insert(p, val);
        end
      end else if (cmd == ple_pkg::CMD_DEL_FIRST || cmd == ple_pkg::CMD_DEL_LAST ||
                   cmd == ple_pkg::CMD_DEL_POS) begin
        if (n == 0) begin
          r.status = ple_pkg::ST_EMPTY;
        end else if (cmd == ple_pkg::CMD_DEL_FIRST) begin
          void'(elems.pop_front());
        end else if (cmd == ple_pkg::CMD_DEL_LAST) begin
          void'(elems.pop_back());
        end else if (pos == 0 || int'(pos) > n) begin
          r.status = ple_pkg::ST_RANGE;
        end else begin
          elems.delete(int'(pos) - 1);
        end
      end
      n = elems.size();
      r.element_count = n[ple_pkg::CountBits-1:0];
      if (n > 0) begin
        r.middle_valid = 1'b1;
        r.middle_value = elems[(n / 2 < 1) ? 0 : n / 2 - 1];
      end
      pending.push_back(r);
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected report", '0, ple_pkg::ValBits'(got.status));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status)
        report_mismatch("status", ple_pkg::ValBits'(want.status),
                        ple_pkg::ValBits'(got.status));
      if (got.element_count !== want.element_count)
        report_mismatch("element_count", ple_pkg::ValBits'(want.element_count),
                        ple_pkg::ValBits'(got.element_count));
      if (got.middle_valid !== want.middle_valid)
        report_mismatch("middle_valid", ple_pkg::ValBits'(want.middle_valid),
                        ple_pkg::ValBits'(got.middle_valid));
      if (got.middle_value !== want.middle_value)
        report_mismatch("middle_value", want.middle_value, got.middle_value);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   sent = 0;
  bit   sending_done = 1'b0;

  ple_in_if  cmd_if();
  ple_out_if rpt_if();
  list_scoreboard board = new();

  positional_list_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if.sink),
    .out_o  (rpt_if.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.cmd = '0;
    cmd_if.position = '0;
    cmd_if.value = '0;
    rpt_if.ready = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  // stretches of back-to-back traffic alternate with gappy ones
  bit calm_phase = 1'b0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 4000 == 0) calm_phase <= $urandom_range(0, 3) == 0;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rpt_if.valid && rpt_if.ready)
      board.check_report({rpt_if.status, rpt_if.element_count, rpt_if.middle_valid,
                          rpt_if.middle_value});
  end

  initial begin : sink_side
    int g;
    @(posedge rst_ni);
    forever begin
      g = calm_phase ? 0 : gap_len();
      if (g > 0) begin
        rpt_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      rpt_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_beat(logic [ple_pkg::CmdBits-1:0] cmd,
                           logic [ple_pkg::PosBits-1:0] pos,
                           logic [ple_pkg::ValBits-1:0] val);
    int g;
    g = calm_phase ? 0 : gap_len();
    if (g > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd <= cmd;
    cmd_if.position <= pos;
    cmd_if.value <= val;
    do @(posedge clk_i); while (!cmd_if.ready);
    board.note_command(cmd, pos, val);
    sent++;
  endtask

  task automatic drain_reports();
    cmd_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ple_pkg::ValBits-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // bias toward positions that exist, with some zero and out-of-range ones
  function automatic logic [ple_pkg::PosBits-1:0] rand_pos();
    int n;
    n = board.elems.size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ple_pkg::PosBits'($urandom_range(0, 127));
      2: return ple_pkg::PosBits'(n + 1);
      3: return ple_pkg::PosBits'(n);
      default: return ple_pkg::PosBits'($urandom_range(1, (n < 1) ? 1 : n));
    endcase
  endfunction

  // insert_pct sets the drift of the list length
  task automatic random_phase(int count, int insert_pct);
    logic [ple_pkg::CmdBits-1:0] cmd;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0)
        cmd = ple_pkg::CmdBits'($urandom_range(6, 7));
      else if ($urandom_range(0, 99) < insert_pct)
        cmd = ple_pkg::CmdBits'($urandom_range(ple_pkg::CMD_INS_FRONT,
                                               ple_pkg::CMD_INS_AFTER));
      else
        cmd = ple_pkg::CmdBits'($urandom_range(ple_pkg::CMD_DEL_FIRST,
                                               ple_pkg::CMD_DEL_POS));
      send_beat(cmd, rand_pos(), rand_value());
    end
  endtask

  initial begin : source_side
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(ple_pkg::CMD_DEL_FIRST, 0, 0);
    send_beat(ple_pkg::CMD_DEL_LAST, 0, 0);
    send_beat(ple_pkg::CMD_DEL_POS, 1, 0);
    send_beat(ple_pkg::CMD_INS_AFTER, 7'd100, 32'h8000_0000);
    send_beat(ple_pkg::CMD_INS_FRONT, 0, 32'h7fff_ffff);
    send_beat(ple_pkg::CMD_INS_BACK, 0, 32'hffff_ffff);
    send_beat(ple_pkg::CMD_INS_AFTER, 0, 32'h0000_0001);
    send_beat(ple_pkg::CMD_INS_AFTER, 4, 32'h5555_5555);
    send_beat(ple_pkg::CMD_INS_AFTER, 3, 32'haaaa_aaaa);
    send_beat(ple_pkg::CMD_INS_AFTER, 7'h7f, 32'h1234_5678);
    send_beat(3'd6, 7'h7f, 32'hffff_ffff);
    send_beat(3'd7, 0, 0);
    send_beat(ple_pkg::CMD_DEL_POS, 0, 0);
    send_beat(ple_pkg::CMD_DEL_POS, 5, 0);
    send_beat(ple_pkg::CMD_DEL_POS, 2, 0);
    send_beat(ple_pkg::CMD_DEL_POS, 3, 0);
    send_beat(ple_pkg::CMD_DEL_LAST, 0, 0);
    send_beat(ple_pkg::CMD_DEL_FIRST, 0, 0);
    send_beat(ple_pkg::CMD_DEL_POS, 1, 0);
    drain_reports();

    // fill to full, hit the full case, then churn and drain
    while (board.elems.size() < Depth)
      send_beat(ple_pkg::CmdBits'($urandom_range(ple_pkg::CMD_INS_FRONT,
                                                 ple_pkg::CMD_INS_AFTER)),
                rand_pos(), rand_value());
    send_beat(ple_pkg::CMD_INS_FRONT, 0, 0);
    send_beat(ple_pkg::CMD_INS_AFTER, 64, 1);
    send_beat(ple_pkg::CMD_INS_BACK, 0, 2);
    send_beat(ple_pkg::CMD_DEL_POS, 64, 0);
    send_beat(ple_pkg::CMD_DEL_POS, 65, 0);
    random_phase(250, 55);
    drain_reports();
    random_phase(300, 30);
    random_phase(400, 70);
    drain_reports();
    random_phase(300, 50);
    random_phase(200, 20);
    drain_reports();

    sending_done = 1'b1;
    repeat (300) @(posedge clk_i);
    $display("covered %0d commands, %0d reports checked, including full, empty and",
             sent, board.checked);
    $display("out-of-range cases and unused command codes");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
